// ----- rtl/tkr_pkg.sv -----
// shared types and constants for the top-k score ranker
package tkr_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int MAX_TILES_DEF = 8;
  localparam int DUMP_LIMIT    = 16;

  localparam logic [2:0] FUNC_SUBMIT    = 3'd0;
  localparam logic [2:0] FUNC_DUMP      = 3'd1;
  localparam logic [2:0] FUNC_READ      = 3'd2;
  localparam logic [2:0] FUNC_CLR_TABLE = 3'd3;
  localparam logic [2:0] FUNC_CLR_CNT   = 3'd4;

  typedef struct packed {
    logic [4:0] row;
    logic [4:0] col;
    logic [7:0] ch;
  } tile_t;

  localparam tile_t EMPTY_TILE = '{row: 5'd31, col: 5'd31, ch: 8'd0};

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] score;
    logic [3:0]  tile_count;
    logic [4:0]  tile_row;
    logic [4:0]  tile_col;
    logic [7:0]  tile_char;
    logic        tile_last;
    logic [3:0]  read_rank;
    logic [2:0]  read_tile;
  } req_t;

  typedef struct packed {
    logic [3:0]  rank;
    logic [15:0] entry_score;
    logic [3:0]  entry_tiles;
    logic [4:0]  out_row;
    logic [4:0]  out_col;
    logic [7:0]  out_char;
    logic        last;
    logic [31:0] submitted;
    logic [31:0] recorded;
  } res_t;

  // insert / clear command broadcast to every cell
  typedef struct packed {
    logic        ins;
    logic        clr;
    logic [15:0] score;
    logic [3:0]  count;
  } cell_cmd_t;

endpackage

// ----- rtl/tkr_cell.sv -----
// one slot of the sorted chain: holds an entry, shifts down or loads on insert
module tkr_cell #(
  parameter int MAX_TILES = tkr_pkg::MAX_TILES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tkr_pkg::cell_cmd_t    cmd,
  input  tkr_pkg::tile_t        new_tiles [MAX_TILES],
  input  logic                  prev_gt,
  input  logic [15:0]           prev_score,
  input  logic [3:0]            prev_count,
  input  tkr_pkg::tile_t        prev_tiles [MAX_TILES],
  output logic                  gt,
  output logic [15:0]           score,
  output logic [3:0]            count,
  output tkr_pkg::tile_t        tiles [MAX_TILES]
);
  import tkr_pkg::*;

  // candidate beats this slot (equal score stays ahead)
  assign gt = cmd.score > score;

  // score and count are control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      score <= '0;
      count <= '0;
    end else if (cmd.ins && prev_gt) begin
      score <= prev_score;
      count <= prev_count;
    end else if (cmd.ins && gt) begin
      score <= cmd.score;
      count <= cmd.count;
    end
  end

  // tile payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.ins && prev_gt) begin
      tiles <= prev_tiles;
    end else if (cmd.ins && gt) begin
      tiles <= new_tiles;
    end
  end

endmodule

// ----- rtl/top_k_score_ranker_top.sv -----
// top level of the top-k score ranker: staging, cell chain, counters, result port
// Keeps the CAPACITY highest scores in a chain of cells sorted by score, each cell
// with its tiles. The insert decision and shift of the whole chain happen in the cycle
// the last tile is accepted, so candidates can stream at one tile per cycle while
// requests are not stalled. A read gives one result in the following cycle through
// the output register. A dump walks the chain one cell per cycle while the output
// register is free, giving one result per held entry (at most 16) and holding off new
// requests until its final result has been registered. Requests stall while the
// output register holds an untaken result.
module top_k_score_ranker_top #(
  parameter int CAPACITY  = tkr_pkg::CAPACITY_DEF,
  parameter int MAX_TILES = tkr_pkg::MAX_TILES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tkr_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output tkr_pkg::res_t res
);
  import tkr_pkg::*;

  localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int IW = $clog2(MAX_TILES + 1);
  localparam int DUMP_END = (CAPACITY < DUMP_LIMIT) ? CAPACITY : DUMP_LIMIT;

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t       state;
  logic [CW:0]  dcnt;
  logic [IW-1:0] stage_idx;
  tile_t        staging [MAX_TILES];
  tile_t        new_tiles [MAX_TILES];
  logic [31:0]  submitted;
  logic [31:0]  recorded;

  cell_cmd_t    cmd;
  logic         gt_q    [CAPACITY];
  logic [15:0]  score_q [CAPACITY];
  logic [3:0]   count_q [CAPACITY];
  tile_t        tiles_q [CAPACITY][MAX_TILES];
  tile_t        zero_tiles [MAX_TILES];

  logic acc, out_free, is_submit, cand_ok, stage_wr;
  tile_t cur_tile;

  assign out_free  = !res_valid || res_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign acc       = req_valid && req_ready;
  assign is_submit = acc && (req.func == FUNC_SUBMIT);
  assign stage_wr  = is_submit && (32'(stage_idx) < MAX_TILES);
  assign cur_tile  = '{row: req.tile_row, col: req.tile_col, ch: req.tile_char};
  assign cand_ok   = (req.tile_count != 4'd0) && (32'(req.tile_count) <= MAX_TILES)
                     && (req.score > score_q[CAPACITY-1]);

  // tiles of the new entry, including the tile arriving now
  always_comb begin
    for (int i = 0; i < MAX_TILES; i++) begin
      zero_tiles[i] = '0;
      if (32'(i) >= 32'(req.tile_count)) begin
        new_tiles[i] = EMPTY_TILE;
      end else if (stage_wr && (32'(stage_idx) == i)) begin
        new_tiles[i] = cur_tile;
      end else begin
        new_tiles[i] = staging[i];
      end
    end
  end

  // command to the chain
  always_comb begin
    cmd.ins   = is_submit && req.tile_last && cand_ok;
    cmd.clr   = acc && (req.func == FUNC_CLR_TABLE);
    cmd.score = req.score;
    cmd.count = req.tile_count;
  end

  // chain of cells, cell 0 holds rank 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      tkr_cell #(.MAX_TILES(MAX_TILES)) u_cell (
        .clk, .rst, .cmd, .new_tiles,
        .prev_gt(1'b0), .prev_score(16'd0), .prev_count(4'd0), .prev_tiles(zero_tiles),
        .gt(gt_q[g]), .score(score_q[g]), .count(count_q[g]), .tiles(tiles_q[g])
      );
    end else begin : g_body
      tkr_cell #(.MAX_TILES(MAX_TILES)) u_cell (
        .clk, .rst, .cmd, .new_tiles,
        .prev_gt(gt_q[g-1]), .prev_score(score_q[g-1]), .prev_count(count_q[g-1]),
        .prev_tiles(tiles_q[g-1]),
        .gt(gt_q[g]), .score(score_q[g]), .count(count_q[g]), .tiles(tiles_q[g])
      );
    end
  end

  // staging buffer payload
  always_ff @(posedge clk) begin
    if (stage_wr) begin
      staging[stage_idx[TW-1:0]] <= cur_tile;
    end
  end

  // read and dump lookups
  logic [CW-1:0] rd_idx, d_idx, dn_idx;
  logic          rd_in, rd_tile_in, d_full, dn_full, d_end, res_load;
  logic [CW:0]   dnext;
  tile_t         rd_tile;

  assign rd_idx     = CW'(req.read_rank);
  assign rd_in      = 32'(req.read_rank) < CAPACITY;
  assign rd_tile_in = rd_in && ({1'b0, req.read_tile} < 4'(count_q[rd_idx]))
                      && (32'(req.read_tile) < MAX_TILES);
  assign rd_tile    = rd_tile_in ? tiles_q[rd_idx][TW'(req.read_tile)] : EMPTY_TILE;
  assign d_idx      = dcnt[CW-1:0];
  assign dnext      = dcnt + 1'b1;
  assign dn_idx     = dnext[CW-1:0];
  assign d_full     = (score_q[d_idx] != 16'd0) && (count_q[d_idx] != 4'd0);
  assign dn_full    = (score_q[dn_idx] != 16'd0) && (count_q[dn_idx] != 4'd0);
  assign d_end      = (32'(dnext) >= DUMP_END) || !dn_full;

  // output register takes a new result
  assign res_load   = (acc && (req.func == FUNC_READ))
                      || ((state == ST_DUMP) && d_full && out_free);

  // control, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dcnt      <= '0;
      stage_idx <= '0;
      submitted <= '0;
      recorded  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            case (req.func)
              FUNC_SUBMIT: begin
                if (stage_wr) begin
                  stage_idx <= stage_idx + 1'b1;
                end
                if (req.tile_last) begin
                  stage_idx <= '0;
                  if (submitted != '1) submitted <= submitted + 1'b1;
                  if (cand_ok && (recorded != '1)) recorded <= recorded + 1'b1;
                end
              end
              FUNC_DUMP: begin
                state <= ST_DUMP;
                dcnt  <= '0;
              end
              FUNC_READ: begin
                res.rank        <= req.read_rank;
                res.entry_score <= rd_in ? score_q[rd_idx] : 16'd0;
                res.entry_tiles <= rd_in ? count_q[rd_idx] : 4'd0;
                res.out_row     <= rd_tile.row;
                res.out_col     <= rd_tile.col;
                res.out_char    <= rd_tile.ch;
                res.last        <= 1'b1;
                res.submitted   <= submitted;
                res.recorded    <= recorded;
              end
              FUNC_CLR_CNT: begin
                submitted <= '0;
                recorded  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DUMP: begin
          if (!d_full) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            res.rank        <= 4'(dcnt);
            res.entry_score <= score_q[d_idx];
            res.entry_tiles <= count_q[d_idx];
            res.out_row     <= EMPTY_TILE.row;
            res.out_col     <= EMPTY_TILE.col;
            res.out_char    <= EMPTY_TILE.ch;
            res.last        <= d_end;
            res.submitted   <= submitted;
            res.recorded    <= recorded;
            dcnt            <= dnext;
            if (d_end) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // accepted entries never outnumber submitted ones
  a_rec_le_sub: assert property (@(posedge clk) disable iff (rst)
    recorded <= submitted) else $error("recorded exceeds submitted");

  // head of the chain never scores below its tail
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    (CAPACITY < 2) || (score_q[0] >= score_q[CAPACITY-1])) else $error("chain unsorted");

  // no request taken during a dump walk
  a_no_req_dump: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> !req_ready) else $error("request taken during dump");

  // a read request yields a last-flagged result next cycle
  a_read_res: assert property (@(posedge clk) disable iff (rst)
    (acc && (req.func == FUNC_READ)) |=> (res_valid && res.last))
    else $error("read gave no result");
`endif

endmodule

// ----- tb/top_k_score_ranker_top_tb.sv -----
// testbench for the top-k score ranker: random and directed requests, predicted results
`timescale 1ns / 100ps

module top_k_score_ranker_top_tb;
  import tkr_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int TILES     = MAX_TILES_DEF;
  localparam int CYCLE_CAP = 400000;

  // ranking table model and the results it predicts
  class rank_scoreboard;
    logic [15:0] ranked_scores [CAP];
    logic [3:0]  ranked_counts [CAP];
    tile_t       ranked_tiles  [CAP][TILES];
    tile_t       staged_tiles  [TILES];
    int unsigned staged_idx;
    logic [31:0] submit_cnt;
    logic [31:0] record_cnt;
    res_t        expected_results[$];
    int          errors;

    function new();
      for (int i = 0; i < CAP; i++) begin
        ranked_scores[i] = '0;
        ranked_counts[i] = '0;
      end
      staged_idx = 0;
      submit_cnt = '0;
      record_cnt = '0;
      errors     = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function res_t make_res(int r, tile_t t, bit lst);
      res_t o;
      o.rank        = r[3:0];
      o.entry_score = ranked_scores[r];
      o.entry_tiles = ranked_counts[r];
      o.out_row     = t.row;
      o.out_col     = t.col;
      o.out_char    = t.ch;
      o.last        = lst;
      o.submitted   = submit_cnt;
      o.recorded    = record_cnt;
      return o;
    endfunction

    // insert decision on the final tile of a candidate
    function void judge(logic [15:0] sc, logic [3:0] cnt);
      int pos;
      if (submit_cnt != '1) submit_cnt++;
      if (cnt < 1 || cnt > TILES) return;
      if (!(sc > ranked_scores[CAP-1])) return;
      if (record_cnt != '1) record_cnt++;
      pos = 0;
      while (pos < CAP - 1 && ranked_scores[pos] >= sc) pos++;
      for (int i = CAP - 1; i > pos; i--) begin
        ranked_scores[i] = ranked_scores[i-1];
        ranked_counts[i] = ranked_counts[i-1];
        for (int k = 0; k < TILES; k++) ranked_tiles[i][k] = ranked_tiles[i-1][k];
      end
      ranked_scores[pos] = sc;
      ranked_counts[pos] = cnt;
      for (int k = 0; k < TILES; k++)
        ranked_tiles[pos][k] = (k < cnt) ? staged_tiles[k] : EMPTY_TILE;
    endfunction

    // accepted request: update state, queue expected results
    function void note(req_t q);
      int   n;
      res_t o;
      tile_t t;
      case (q.func)
        FUNC_SUBMIT: begin
          if (staged_idx < TILES) begin
            staged_tiles[staged_idx] = '{row: q.tile_row, col: q.tile_col, ch: q.tile_char};
            staged_idx++;
          end
          if (q.tile_last) begin
            judge(q.score, q.tile_count);
            staged_idx = 0;
          end
        end
        FUNC_DUMP: begin
          n = 0;
          for (int i = 0; i < CAP && n < DUMP_LIMIT; i++)
            if (ranked_scores[i] > 0 && ranked_counts[i] > 0) begin
              expected_results = {expected_results, make_res(i, EMPTY_TILE, 1'b0)};
              n++;
            end
          if (n > 0) expected_results[expected_results.size()-1].last = 1'b1;
        end
        FUNC_READ: begin
          t = (q.read_tile < ranked_counts[q.read_rank]) ?
              ranked_tiles[q.read_rank][q.read_tile] : EMPTY_TILE;
          o = make_res(q.read_rank, t, 1'b1);
          expected_results = {expected_results, o};
        end
        FUNC_CLR_TABLE: begin
          for (int i = 0; i < CAP; i++) begin
            ranked_scores[i] = '0;
            ranked_counts[i] = '0;
          end
        end
        FUNC_CLR_CNT: begin
          submit_cnt = '0;
          record_cnt = '0;
        end
        default: ;
      endcase
    endfunction

    // compare one accepted result with the oldest expectation
    task check(res_t g);
      res_t w;
      if (expected_results.size() == 0) begin
        report("unexpected result, rank", g.rank, 0);
        return;
      end
      w = expected_results.pop_front();
      if (g.rank        !== w.rank)        report("rank", g.rank, w.rank);
      if (g.entry_score !== w.entry_score) report("entry_score", g.entry_score, w.entry_score);
      if (g.entry_tiles !== w.entry_tiles) report("entry_tiles", g.entry_tiles, w.entry_tiles);
      if (g.out_row     !== w.out_row)     report("out_row", g.out_row, w.out_row);
      if (g.out_col     !== w.out_col)     report("out_col", g.out_col, w.out_col);
      if (g.out_char    !== w.out_char)    report("out_char", g.out_char, w.out_char);
      if (g.last        !== w.last)        report("last", g.last, w.last);
      if (g.submitted   !== w.submitted)   report("submitted", g.submitted, w.submitted);
      if (g.recorded    !== w.recorded)    report("recorded", g.recorded, w.recorded);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  rank_scoreboard sb = new();
  req_t    stim_q[$];
  int      gen_idx = 0;
  int      gen_hi = 0;
  bit      hold_off = 1'b0;
  int      ready_pct = 100;
  longint  cycles = 0;

  top_k_score_ranker_top uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // request with every field random
  function automatic req_t rand_req();
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    return r[$bits(req_t)-1:0];
  endfunction

  // queue one request; tracks staging so no unwritten slot is ever copied
  task automatic add_req(req_t q);
    if (q.func == FUNC_SUBMIT) begin
      if (gen_idx < TILES) begin
        gen_idx++;
        if (gen_idx > gen_hi) gen_hi = gen_idx;
      end
      if (q.tile_last) begin
        if (q.tile_count >= 1 && q.tile_count <= TILES && q.tile_count > gen_hi)
          q.tile_count = gen_hi[3:0];
        gen_idx = 0;
      end
    end
    stim_q = {stim_q, q};
  endtask

  // a whole candidate of n tiles with random content
  task automatic add_candidate(int n, logic [15:0] sc, logic [3:0] cnt);
    req_t q;
    for (int i = 0; i < n; i++) begin
      q = rand_req();
      q.func       = FUNC_SUBMIT;
      q.tile_last  = (i == n - 1);
      q.score      = sc;
      q.tile_count = cnt;
      add_req(q);
    end
  endtask

  task automatic add_op(logic [2:0] f, int rr, int rt);
    req_t q;
    q = rand_req();
    q.func      = f;
    q.read_rank = rr[3:0];
    q.read_tile = rt[2:0];
    add_req(q);
  endtask

  // directed part: extremes, rejects, ties, empty reads, every func
  task automatic build_directed();
    add_op(FUNC_DUMP, 0, 0);
    add_op(FUNC_READ, 0, 0);
    add_candidate(1, 16'hFFFF, 4'd1);
    add_candidate(8, 16'd1, 4'd8);
    add_candidate(2, 16'd500, 4'd0);
    add_candidate(10, 16'd600, 4'd15);
    add_candidate(3, 16'd1, 4'd3);
    add_candidate(4, 16'd1, 4'd6);
    add_candidate(1, 16'd0, 4'd1);
    add_op(FUNC_DUMP, 0, 0);
    add_op(FUNC_READ, 0, 0);
    add_op(FUNC_READ, 1, 7);
    add_op(FUNC_READ, 3, 5);
    add_op(FUNC_READ, 15, 7);
    add_op(3'd5, 0, 0);
    add_op(3'd7, 0, 0);
    add_op(FUNC_CLR_CNT, 0, 0);
    add_op(FUNC_READ, 0, 1);
    add_op(FUNC_CLR_TABLE, 0, 0);
    add_op(FUNC_DUMP, 0, 0);
  endtask

  // random part: mostly whole candidates, some reads, dumps, clears and noise
  task automatic build_random();
    int k;
    int n;
    logic [15:0] sc;
    logic [3:0]  cnt;
    req_t q;
    for (int it = 0; it < 40; it++) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        n  = $urandom_range(1, TILES);
        sc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom) : n[3:0];
        if ($urandom_range(0, 15) == 0) n = $urandom_range(9, 12);
        add_candidate(n, sc, cnt);
      end else if (k < 70) begin
        add_op(FUNC_DUMP, 0, 0);
      end else if (k < 90) begin
        add_op(FUNC_READ, $urandom_range(0, 15), $urandom_range(0, 7));
      end else if (k < 93) begin
        add_op(FUNC_CLR_TABLE, 0, 0);
      end else if (k < 96) begin
        add_op(FUNC_CLR_CNT, 0, 0);
      end else begin
        q = rand_req();
        if (q.func < 3'd5) q.func = FUNC_SUBMIT;
        add_req(q);
      end
    end
  endtask

  // sender: bursts of random length with random gaps
  task automatic drive_all();
    int burst;
    req_t q;
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && stim_q.size() > 0) begin
        q = stim_q.pop_front();
        req_valid <= 1'b1;
        req <= q;
        do @(posedge clk); while (!req_ready);
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    req_valid <= 1'b0;
  endtask

  // receiver stall pattern with a re-picked ready percentage
  always @(posedge clk) begin
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pct <= 100;
        1: ready_pct <= 60;
        default: ready_pct <= 25;
      endcase
    end
    res_ready <= !rst && !hold_off && ($urandom_range(0, 99) < ready_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    repeat (80) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // accepted requests and results
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) sb.note(req);
    if (!rst && res_valid && res_ready) sb.check(res);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("top_k_score_ranker_top_tb failed");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_all();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.report("results never arrived", sb.expected_results.size(), 0);
    end
    if (sb.errors == 0) begin
      $display("top_k_score_ranker_top_tb passed");
    end else begin
      $display("top_k_score_ranker_top_tb failed");
    end
    $finish;
  end

endmodule
